FILE: rtl/core/spint_pkg.sv
// Shared types and constants for the servo pose interpolator.
// Used by spint_div, spint_dp, spint_ctrl and servo_pose_interpolator_unit.
`default_nettype none
package spint_pkg;

  localparam int MAX_SLOTS_DEF  = 16;
  localparam int POSE_SHIFT_DEF = 3;

  localparam int CNT_W  = 5;   // slot counts and indexes
  localparam int POSE_W = 16;
  localparam int DVD_W  = 17;  // divider dividend / quotient
  localparam int DVS_W  = 16;  // divider divisor

  localparam logic [2:0] FN_LOAD   = 3'd0;
  localparam logic [2:0] FN_SETCUR = 3'd1;
  localparam logic [2:0] FN_START  = 3'd2;
  localparam logic [2:0] FN_ABORT  = 3'd3;
  localparam logic [2:0] FN_FRAME  = 3'd4;

  localparam logic [0:0] REG_FRAME_TIME  = 1'd0;
  localparam logic [0:0] REG_SERVO_COUNT = 1'd1;

  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] BCAST_ID     = 8'hFE;
  localparam logic [7:0] SYNC_WRITE   = 8'h83;
  localparam logic [7:0] GOAL_POS_REG = 8'h1E;
  localparam logic [7:0] GOAL_POS_LEN = 8'h02;
  localparam logic [11:0] FAIL_POS    = 12'd512;
  localparam logic [7:0] FRAME_TIME_RST = 8'd20;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LOAD,
    DP_SETCUR,
    DP_START_INIT,
    DP_ITERS,
    DP_SLOT_EQ,
    DP_SLOT_DIV,
    DP_SLOT_WR,
    DP_START_FIN,
    DP_ABORT_STEP,
    DP_ABORT_FIN,
    DP_SCAN_STEP,
    DP_BODY_INIT,
    DP_SKIP,
    DP_EMIT,
    DP_FRAME_FIN
  } dp_op_t;

  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_BODY,
    SEL_CSUM
  } emit_sel_t;

  typedef struct packed {
    dp_op_t    op;
    emit_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_end_n;
    logic idx_end_lim;
    logic differ;
    logic goal_differ;
    logic moving_zero;
    logic div_done;
    logic hb_last;
    logic sb_last;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/spint_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on spint_pkg for widths.
`default_nettype none
module spint_div
  import spint_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: rtl/core/spint_dp.sv
// Datapath: slot state arrays, config registers, counters, packet bytes.
// Depends on spint_pkg and spint_div.
`default_nettype none
module spint_dp
  import spint_pkg::*;
#(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int POSE_SHIFT = POSE_SHIFT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  input  wire logic [2:0]  in_func,
  input  wire logic [3:0]  in_slot,
  input  wire logic [7:0]  in_servo_id,
  input  wire logic [11:0] in_position,
  input  wire logic        in_read_failed,
  input  wire logic [15:0] in_move_time_ms,
  input  wire logic        cfg_fire,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic [7:0]       out_packet_byte,
  output logic             out_last,
  output logic [4:0]       out_moving_count
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_SLOTS);

  logic [POSE_W-1:0] cur_r  [MAX_SLOTS];
  logic [POSE_W-1:0] tgt_r  [MAX_SLOTS];
  logic [POSE_W-1:0] step_r [MAX_SLOTS];
  logic [7:0]        id_r   [MAX_SLOTS];
  logic [11:0]       goal_r [MAX_SLOTS];

  logic [7:0]        frame_time_r;
  logic [CNT_W-1:0]  servo_count_r;
  logic [CNT_W-1:0]  slots_in_use_r;
  logic [CNT_W-1:0]  moving_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  still_r;
  logic signed [6:0] cnt_r;
  logic [7:0]        sum_r;
  logic [2:0]        hb_r;
  logic [1:0]        sb_r;
  logic [DVS_W-1:0]  iters_r;
  logic [15:0]       mtime_r;
  logic [7:0]        sid_r;
  logic [11:0]       pos_r;
  logic              failed_r;

  logic [AW-1:0]     a;
  logic              idx_ok;
  logic [POSE_W-1:0] cur, tgt, st, delta, newcur, goal_s, gdist;
  logic              up, snap;
  logic [CNT_W-1:0]  n_act;
  logic [7:0]        ft;
  logic [7:0]        len;
  logic [POSE_W-1:0] pout;
  logic [7:0]        hdr_byte, body_byte, byte_out;
  logic [11:0]       p_set;
  logic              div_start, div_busy, div_done;
  logic [DVD_W-1:0]  div_dvd, quo;
  logic [DVS_W-1:0]  div_dvs;
  logic signed [6:0] cnt_dec;

  assign a      = idx_r[AW-1:0];
  assign idx_ok = idx_r < MAXC;
  assign cur    = cur_r[a];
  assign tgt    = tgt_r[a];
  assign st     = step_r[a];
  assign up     = tgt > cur;
  assign delta  = up ? tgt - cur : cur - tgt;
  assign snap   = delta <= st;
  assign newcur = snap ? tgt : (up ? cur + st : cur - st);
  assign goal_s = POSE_W'({4'b0, goal_r[a]} << POSE_SHIFT);
  assign gdist  = (goal_s > cur) ? goal_s - cur : cur - goal_s;
  assign n_act  = (servo_count_r > MAXC) ? MAXC : servo_count_r;
  assign ft     = (frame_time_r == 8'd0) ? 8'd1 : frame_time_r;
  assign len    = 8'd4 + 8'({k_r, 1'b0}) + 8'(k_r);
  assign pout   = newcur >> POSE_SHIFT;
  assign p_set  = failed_r ? FAIL_POS : pos_r;
  assign cnt_dec = (st != '0) ? cnt_r - 7'sd1 : cnt_r;

  always_comb begin
    case (hb_r)
      3'd0, 3'd1: hdr_byte = HDR_BYTE;
      3'd2:       hdr_byte = BCAST_ID;
      3'd3:       hdr_byte = len;
      3'd4:       hdr_byte = SYNC_WRITE;
      3'd5:       hdr_byte = GOAL_POS_REG;
      default:    hdr_byte = GOAL_POS_LEN;
    endcase
  end

  always_comb begin
    case (sb_r)
      2'd0:    body_byte = id_r[a];
      2'd1:    body_byte = pout[7:0];
      default: body_byte = pout[15:8];
    endcase
  end

  always_comb begin
    case (cmd.sel)
      SEL_HDR:  byte_out = hdr_byte;
      SEL_BODY: byte_out = body_byte;
      default:  byte_out = ~sum_r;
    endcase
  end

  assign div_start = (cmd.op == DP_START_INIT) || (cmd.op == DP_SLOT_DIV);
  assign div_dvd   = (cmd.op == DP_START_INIT) ?
                     DVD_W'(mtime_r) + DVD_W'(ft) - DVD_W'(1) : DVD_W'(gdist);
  assign div_dvs   = (cmd.op == DP_START_INIT) ? DVS_W'(ft) : iters_r;

  spint_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // config and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r   <= FRAME_TIME_RST;
      servo_count_r  <= '0;
      slots_in_use_r <= '0;
      moving_r       <= '0;
      idx_r          <= '0;
      k_r            <= '0;
      still_r        <= '0;
      cnt_r          <= '0;
      sum_r          <= '0;
      hb_r           <= '0;
      sb_r           <= '0;
    end else begin
      if (cfg_fire) begin
        if (cfg_index == REG_FRAME_TIME) frame_time_r <= cfg_data;
        else servo_count_r <= cfg_data[CNT_W-1:0];
      end
      case (cmd.op)
        DP_CAPTURE: begin
          idx_r   <= (in_func == FN_LOAD || in_func == FN_SETCUR) ?
                     {1'b0, in_slot} : '0;
          k_r     <= '0;
          still_r <= '0;
          sum_r   <= '0;
          hb_r    <= '0;
          sb_r    <= '0;
          cnt_r   <= 7'(moving_r);
        end
        DP_SETCUR: begin
          if (idx_ok && st != '0 && moving_r != '0) moving_r <= moving_r - 1'b1;
        end
        DP_START_INIT: begin
          if (n_act >= slots_in_use_r) slots_in_use_r <= n_act;
        end
        DP_SLOT_EQ: begin
          cnt_r <= cnt_dec;
          idx_r <= idx_r + 1'b1;
        end
        DP_SLOT_WR: begin
          cnt_r <= cnt_dec + 7'sd1;
          idx_r <= idx_r + 1'b1;
        end
        DP_START_FIN: begin
          if (cnt_r < 0) moving_r <= '0;
          else if (cnt_r > 7'sd31) moving_r <= 5'd31;
          else moving_r <= cnt_r[4:0];
        end
        DP_ABORT_STEP: idx_r <= idx_r + 1'b1;
        DP_ABORT_FIN:  moving_r <= '0;
        DP_SCAN_STEP: begin
          if (tgt != cur) begin
            k_r <= k_r + 1'b1;
            if (!snap) still_r <= still_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        DP_BODY_INIT: idx_r <= '0;
        DP_SKIP:      idx_r <= idx_r + 1'b1;
        DP_EMIT: begin
          if (cmd.sel == SEL_HDR) begin
            if (hb_r >= 3'd2) sum_r <= sum_r + byte_out;
            hb_r <= hb_r + 3'd1;
          end else if (cmd.sel == SEL_BODY) begin
            sum_r <= sum_r + byte_out;
            if (sb_r == 2'd2) begin
              sb_r  <= '0;
              idx_r <= idx_r + 1'b1;
            end else begin
              sb_r <= sb_r + 2'd1;
            end
          end
        end
        DP_FRAME_FIN: moving_r <= still_r;
        default: ;
      endcase
    end
  end

  // slot arrays with reset value zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        cur_r[i]  <= '0;
        tgt_r[i]  <= '0;
        step_r[i] <= '0;
        id_r[i]   <= '0;
      end
    end else begin
      case (cmd.op)
        DP_LOAD: if (idx_ok) id_r[a] <= sid_r;
        DP_SETCUR: begin
          if (idx_ok) begin
            cur_r[a]  <= POSE_W'({4'b0, p_set} << POSE_SHIFT);
            tgt_r[a]  <= POSE_W'({4'b0, p_set} << POSE_SHIFT);
            step_r[a] <= '0;
          end
        end
        DP_SLOT_EQ: begin
          tgt_r[a]  <= goal_s;
          step_r[a] <= '0;
        end
        DP_SLOT_WR: begin
          tgt_r[a]  <= goal_s;
          step_r[a] <= quo[DVS_W-1:0] + 16'd1;
        end
        DP_ABORT_STEP: begin
          tgt_r[a]  <= cur;
          step_r[a] <= '0;
        end
        DP_EMIT: begin
          if (cmd.sel == SEL_BODY && sb_r == 2'd2) begin
            cur_r[a] <= newcur;
            if (snap) step_r[a] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD && idx_ok) goal_r[a] <= pos_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      mtime_r  <= in_move_time_ms;
      sid_r    <= in_servo_id;
      pos_r    <= in_position;
      failed_r <= in_read_failed;
    end
    if (cmd.op == DP_ITERS)
      iters_r <= (quo == '0) ? DVS_W'(1) : quo[DVS_W-1:0];
  end

  assign status.idx_end_n   = idx_r >= n_act;
  assign status.idx_end_lim = idx_r >= slots_in_use_r;
  assign status.differ      = tgt != cur;
  assign status.goal_differ = goal_s != cur;
  assign status.moving_zero = moving_r == '0;
  assign status.div_done    = div_done;
  assign status.hb_last     = hb_r == 3'd6;
  assign status.sb_last     = sb_r == 2'd2;

  assign out_packet_byte  = byte_out;
  assign out_last         = cmd.sel == SEL_CSUM;
  assign out_moving_count = still_r;

  a_still_le_k: assert property (@(posedge clk) disable iff (!rst_n) still_r <= k_r)
    else $error("still count exceeds moving slot count");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= MAXC)
    else $error("slot index beyond slot count");
  a_siu_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slots_in_use_r <= MAXC)
    else $error("slots in use beyond slot count");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

FILE: rtl/core/spint_ctrl.sv
// Sequencer for the interpolator: decodes items and steps the datapath.
// Depends on spint_pkg.
`default_nettype none
module spint_ctrl
  import spint_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_func,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SETCUR, S_ITER, S_ITER_WAIT, S_SLOT, S_SLOT_WAIT,
    S_ABORT, S_SCAN, S_HDR, S_BODY, S_BYTES, S_CSUM
  } state_t;

  state_t state_r, state_nxt;
  logic   fire;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = (state_r == S_HDR) || (state_r == S_BYTES) || (state_r == S_CSUM);
  assign fire      = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    cmd.sel   = SEL_HDR;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_CAPTURE;
          case (in_func)
            FN_LOAD:   state_nxt = S_LOAD;
            FN_SETCUR: state_nxt = S_SETCUR;
            FN_START:  state_nxt = S_ITER;
            FN_ABORT:  state_nxt = S_ABORT;
            FN_FRAME:  state_nxt = S_SCAN;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op = DP_LOAD;
        state_nxt = S_IDLE;
      end
      S_SETCUR: begin
        cmd.op = DP_SETCUR;
        state_nxt = S_IDLE;
      end
      S_ITER: begin
        cmd.op = DP_START_INIT;
        state_nxt = S_ITER_WAIT;
      end
      S_ITER_WAIT: begin
        if (status.div_done) begin
          cmd.op = DP_ITERS;
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        if (status.idx_end_n) begin
          cmd.op = DP_START_FIN;
          state_nxt = S_IDLE;
        end else if (!status.goal_differ) begin
          cmd.op = DP_SLOT_EQ;
        end else begin
          cmd.op = DP_SLOT_DIV;
          state_nxt = S_SLOT_WAIT;
        end
      end
      S_SLOT_WAIT: begin
        if (status.div_done) begin
          cmd.op = DP_SLOT_WR;
          state_nxt = S_SLOT;
        end
      end
      S_ABORT: begin
        if (status.idx_end_n) begin
          cmd.op = DP_ABORT_FIN;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = DP_ABORT_STEP;
        end
      end
      S_SCAN: begin
        if (status.moving_zero) begin
          state_nxt = S_IDLE;
        end else if (status.idx_end_lim) begin
          cmd.op = DP_BODY_INIT;
          state_nxt = S_HDR;
        end else begin
          cmd.op = DP_SCAN_STEP;
        end
      end
      S_HDR: begin
        cmd.sel = SEL_HDR;
        if (fire) begin
          cmd.op = DP_EMIT;
          if (status.hb_last) state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        cmd.sel = SEL_BODY;
        if (status.idx_end_lim) state_nxt = S_CSUM;
        else if (!status.differ) cmd.op = DP_SKIP;
        else state_nxt = S_BYTES;
      end
      S_BYTES: begin
        cmd.sel = SEL_BODY;
        if (fire) begin
          cmd.op = DP_EMIT;
          if (status.sb_last) state_nxt = S_BODY;
        end
      end
      S_CSUM: begin
        cmd.sel = SEL_CSUM;
        if (fire) begin
          cmd.op = DP_FRAME_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_csum_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CSUM && fire) |=> in_ready)
    else $error("no return to idle after checksum transfer");
  a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLOT_WAIT && !status.div_done) |=> state_r == S_SLOT_WAIT)
    else $error("left divider wait early");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while packet pending");

endmodule
`default_nettype wire

FILE: rtl/core/servo_pose_interpolator_unit.sv
// Servo pose interpolator top: load, set-current, abort and start items. Start
// runs the serial divider (one quotient bit a cycle) once for the frame count
// and once per slot whose goal differs from its pose. A frame tick with moving
// slots scans the slots in use (one a cycle), sends 8 + 3*k bytes (one per
// transfer). One item at a time. Sync active-low reset clears slots but goals.
`default_nettype none
module servo_pose_interpolator_unit
  import spint_pkg::*;
#(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int POSE_SHIFT = POSE_SHIFT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [3:0]  in_slot,
  input  wire logic [7:0]  in_servo_id,
  input  wire logic [11:0] in_position,
  input  wire logic        in_read_failed,
  input  wire logic [15:0] in_move_time_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_packet_byte,
  output logic             out_last,
  output logic [4:0]       out_moving_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  spint_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  spint_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .POSE_SHIFT (POSE_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .in_servo_id      (in_servo_id),
    .in_position      (in_position),
    .in_read_failed   (in_read_failed),
    .in_move_time_ms  (in_move_time_ms),
    .cfg_fire         (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_packet_byte  (out_packet_byte),
    .out_last         (out_last),
    .out_moving_count (out_moving_count)
  );

endmodule
`default_nettype wire
